// ===== hdl/bgll_pkg.sv =====
// Shared types, register codes and power tables for the block group layout locator.
// Used by every module in hdl/; depends on nothing.
`timescale 1ns / 1ps

package bgll_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int GROUP_W = 32;
    localparam int LOC_W   = 33;
    localparam int BPG_W   = 20;
    localparam int DPB_W   = 12;
    localparam int FLAGS_W = 4;

    // Feature flag bit positions
    localparam int FLAG_META_BG       = 0;
    localparam int FLAG_SPARSE_SUPER  = 1;
    localparam int FLAG_SPARSE_SUPER2 = 2;
    localparam int FLAG_CLUSTER_ADJ   = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_DATA_BLOCK      = 3'd0,
        REG_BLOCKS_PER_GROUP      = 3'd1,
        REG_DESCRIPTORS_PER_BLOCK = 3'd2,
        REG_FIRST_META_BG         = 3'd3,
        REG_BACKUP_GROUP_A        = 3'd4,
        REG_BACKUP_GROUP_B        = 3'd5,
        REG_FEATURE_FLAGS         = 3'd6
    } cfg_reg_t;

    // Register reset values
    localparam logic               RST_FIRST_DATA_BLOCK      = 1'b0;
    localparam logic [BPG_W-1:0]   RST_BLOCKS_PER_GROUP      = 20'd32768;
    localparam logic [DPB_W-1:0]   RST_DESCRIPTORS_PER_BLOCK = 12'd128;
    localparam logic [GROUP_W-1:0] RST_FIRST_META_BG         = 32'd0;
    localparam logic [GROUP_W-1:0] RST_BACKUP_GROUP_A        = 32'd1;
    localparam logic [GROUP_W-1:0] RST_BACKUP_GROUP_B        = 32'd0;
    localparam logic [FLAGS_W-1:0] RST_FEATURE_FLAGS         = 4'd2;

    // Query kinds
    localparam logic CMD_GROUP = 1'b0;
    localparam logic CMD_DESC  = 1'b1;

    // Input and result items
    typedef struct packed {
        logic               cmd;
        logic [GROUP_W-1:0] index;
    } in_item_t;

    typedef struct packed {
        logic [LOC_W-1:0] location;
        logic             has_superblock;
    } out_item_t;

    // Powers of 3, 5 and 7 (exponent one and up) that fit in 32 bits
    localparam int POW3_N = 20;
    localparam int POW5_N = 13;
    localparam int POW7_N = 11;

    localparam logic [GROUP_W-1:0] POW3_TBL [POW3_N] = '{
        32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187, 32'd6561,
        32'd19683, 32'd59049, 32'd177147, 32'd531441, 32'd1594323,
        32'd4782969, 32'd14348907, 32'd43046721, 32'd129140163,
        32'd387420489, 32'd1162261467, 32'd3486784401
    };

    localparam logic [GROUP_W-1:0] POW5_TBL [POW5_N] = '{
        32'd5, 32'd25, 32'd125, 32'd625, 32'd3125, 32'd15625, 32'd78125,
        32'd390625, 32'd1953125, 32'd9765625, 32'd48828125, 32'd244140625,
        32'd1220703125
    };

    localparam logic [GROUP_W-1:0] POW7_TBL [POW7_N] = '{
        32'd7, 32'd49, 32'd343, 32'd2401, 32'd16807, 32'd117649, 32'd823543,
        32'd5764801, 32'd40353607, 32'd282475249, 32'd1977326743
    };

endpackage

// ===== hdl/bgll_sb_check.sv =====
// Superblock copy test for one group number: backup rules and power tables.
// Depends on bgll_pkg.
`timescale 1ns / 1ps

module bgll_sb_check (
    input  logic [bgll_pkg::GROUP_W-1:0] group,
    input  logic [bgll_pkg::FLAGS_W-1:0] flags,
    input  logic [bgll_pkg::GROUP_W-1:0] backup_a,
    input  logic [bgll_pkg::GROUP_W-1:0] backup_b,
    output logic                         has_super
);

    logic pow_hit;

    // Match against every tabulated power in parallel
    always_comb
    begin
        pow_hit = 1'b0;
        for (int i = 0; i < bgll_pkg::POW3_N; i++)
        begin
            if (group == bgll_pkg::POW3_TBL[i])
                pow_hit = 1'b1;
        end
        for (int i = 0; i < bgll_pkg::POW5_N; i++)
        begin
            if (group == bgll_pkg::POW5_TBL[i])
                pow_hit = 1'b1;
        end
        for (int i = 0; i < bgll_pkg::POW7_N; i++)
        begin
            if (group == bgll_pkg::POW7_TBL[i])
                pow_hit = 1'b1;
        end
    end

    // Group zero always, sparse_super2 by backup list, every group without sparse_super, else group one and odd powers
    always_comb
    begin
        if (group == '0)
            has_super = 1'b1;
        else if (flags[bgll_pkg::FLAG_SPARSE_SUPER2])
            has_super = (group == backup_a) || (group == backup_b);
        else if (group == bgll_pkg::GROUP_W'(1) || !flags[bgll_pkg::FLAG_SPARSE_SUPER])
            has_super = 1'b1;
        else
            has_super = group[0] && pow_hit;
    end

endmodule

// ===== hdl/block_group_layout_locator_core.sv =====
// Top level of the block group layout locator: config registers and 4-stage pipeline.
// Depends on bgll_pkg and bgll_sb_check.
`timescale 1ns / 1ps

// Answers one layout query per item: the start block of a group and whether it
// carries a superblock copy, or the location of a group descriptor block under
// the flat or meta_bg rule. One item is accepted every clock cycle while
// in_stall is low; each item passes through the stages in order
// (descriptor-to-group multiply, group times blocks-per-group multiply with
// the superblock test, start block add, final location add into the output
// register). Every stage holds its item under out_stall and a bubble in any
// stage is filled, so in_stall rises only when all four stages are full and
// the output is stalled. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no item is in flight.

module block_group_layout_locator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bgll_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bgll_pkg::out_item_t             out_item,
    input  logic                            cfg_we,
    input  logic [bgll_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgll_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW   = bgll_pkg::GROUP_W;
    localparam int M1_W = bgll_pkg::DPB_W + GW;
    localparam int M2_W = bgll_pkg::BPG_W + GW;

    // Configuration registers
    logic                          fdb_reg;
    logic [bgll_pkg::BPG_W-1:0]    bpg_reg;
    logic [bgll_pkg::DPB_W-1:0]    dpb_reg;
    logic [GW-1:0]                 fmb_reg;
    logic [GW-1:0]                 backup_a_reg;
    logic [GW-1:0]                 backup_b_reg;
    logic [bgll_pkg::FLAGS_W-1:0]  flags_reg;

    // Stage valids and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // Stage 1: group number and query kind
    logic          s1_flat_next;
    logic [M1_W-1:0] s1_mul;
    logic [GW-1:0] s1_group_next;
    logic          s1_flat_reg;
    logic          s1_meta_reg;
    logic [GW-1:0] s1_group_reg;

    // Stage 2: product, superblock bit, group-zero mark
    logic [M2_W-1:0] s2_mul;
    logic          s2_sb_calc;
    logic [GW-1:0] s2_prod_next;
    logic          s2_gzero_next;
    logic [GW-1:0] s2_prod_reg;
    logic          s2_sb_reg;
    logic          s2_gzero_reg;
    logic          s2_flat_reg;
    logic          s2_meta_reg;
    logic [GW-1:0] s2_group_reg;

    // Stage 3: truncated start block and addend
    logic [GW-1:0] s3_start_next;
    logic [GW-1:0] s3_addend_next;
    logic          s3_inc_next;
    logic [GW-1:0] s3_start_reg;
    logic [GW-1:0] s3_addend_reg;
    logic          s3_inc_reg;
    logic          s3_sb_reg;

    // Stage 4: output register
    logic [bgll_pkg::LOC_W-1:0] s4_loc_next;
    logic [bgll_pkg::LOC_W-1:0] s4_loc_reg;
    logic                       s4_sb_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg      <= bgll_pkg::RST_FIRST_DATA_BLOCK;
            bpg_reg      <= bgll_pkg::RST_BLOCKS_PER_GROUP;
            dpb_reg      <= bgll_pkg::RST_DESCRIPTORS_PER_BLOCK;
            fmb_reg      <= bgll_pkg::RST_FIRST_META_BG;
            backup_a_reg <= bgll_pkg::RST_BACKUP_GROUP_A;
            backup_b_reg <= bgll_pkg::RST_BACKUP_GROUP_B;
            flags_reg    <= bgll_pkg::RST_FEATURE_FLAGS;
        end
        else if (cfg_we)
        begin
            case (bgll_pkg::cfg_reg_t'(cfg_index))
                bgll_pkg::REG_FIRST_DATA_BLOCK:      fdb_reg      <= cfg_data[0];
                bgll_pkg::REG_BLOCKS_PER_GROUP:
                    bpg_reg <= cfg_data[bgll_pkg::BPG_W-1:0];
                bgll_pkg::REG_DESCRIPTORS_PER_BLOCK:
                    dpb_reg <= cfg_data[bgll_pkg::DPB_W-1:0];
                bgll_pkg::REG_FIRST_META_BG:         fmb_reg      <= cfg_data[GW-1:0];
                bgll_pkg::REG_BACKUP_GROUP_A:        backup_a_reg <= cfg_data[GW-1:0];
                bgll_pkg::REG_BACKUP_GROUP_B:        backup_b_reg <= cfg_data[GW-1:0];
                bgll_pkg::REG_FEATURE_FLAGS:
                    flags_reg <= cfg_data[bgll_pkg::FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next one advances
    assign s4_ready = !s4_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: pick flat rule, map descriptor block to its group
    always_comb
    begin
        s1_flat_next = (in_item.cmd == bgll_pkg::CMD_DESC) &&
                       (!flags_reg[bgll_pkg::FLAG_META_BG] || in_item.index < fmb_reg);
        s1_mul       = M1_W'(dpb_reg) * M1_W'(in_item.index);
        if (in_item.cmd == bgll_pkg::CMD_DESC && !s1_flat_next)
            s1_group_next = s1_mul[GW-1:0];
        else
            s1_group_next = in_item.index;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_flat_reg  <= s1_flat_next;
            s1_meta_reg  <= (in_item.cmd == bgll_pkg::CMD_DESC) && !s1_flat_next;
            s1_group_reg <= s1_group_next;
        end
    end

    // Stage 2: group times blocks per group, superblock test
    bgll_sb_check u_sb_check (
        .group     (s1_group_reg),
        .flags     (flags_reg),
        .backup_a  (backup_a_reg),
        .backup_b  (backup_b_reg),
        .has_super (s2_sb_calc)
    );

    always_comb
    begin
        s2_mul = M2_W'(bpg_reg) * M2_W'(s1_group_reg);
        if (s1_flat_reg)
        begin
            // Flat rule works from group zero
            s2_prod_next  = '0;
            s2_gzero_next = 1'b1;
        end
        else
        begin
            s2_prod_next  = s2_mul[GW-1:0];
            s2_gzero_next = (s1_group_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_prod_reg  <= s2_prod_next;
            s2_sb_reg    <= s1_flat_reg ? 1'b1 : s2_sb_calc;
            s2_gzero_reg <= s2_gzero_next;
            s2_flat_reg  <= s1_flat_reg;
            s2_meta_reg  <= s1_meta_reg;
            s2_group_reg <= s1_group_reg;
        end
    end

    // Stage 3: start block modulo 2^32, cluster adjust on group zero
    always_comb
    begin
        s3_start_next  = s2_prod_reg + GW'(fdb_reg) +
                         GW'(s2_gzero_reg && flags_reg[bgll_pkg::FLAG_CLUSTER_ADJ]);
        s3_addend_next = s2_flat_reg ? s2_group_reg : '0;
        s3_inc_next    = s2_flat_reg || (s2_meta_reg && s2_sb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_start_reg  <= s3_start_next;
            s3_addend_reg <= s3_addend_next;
            s3_inc_reg    <= s3_inc_next;
            s3_sb_reg     <= s2_sb_reg;
        end
    end

    // Stage 4: full-width location add
    assign s4_loc_next = bgll_pkg::LOC_W'(s3_start_reg) + bgll_pkg::LOC_W'(s3_addend_reg) +
                         bgll_pkg::LOC_W'(s3_inc_reg);

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_loc_reg <= s4_loc_next;
            s4_sb_reg  <= s3_sb_reg;
        end
    end

    assign out_valid               = s4_valid_reg;
    assign out_item.location       = s4_loc_reg;
    assign out_item.has_superblock = s4_sb_reg;

endmodule

// ===== hdl/bgll_checker.sv =====
// Port-level checks on the block group layout locator, bound to the top level.
// Depends on bgll_pkg and block_group_layout_locator_core.
`timescale 1ns / 1ps

module bgll_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input bgll_pkg::out_item_t out_item
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item changed or vanished");

    // Empty output stage means the pipeline can take an item
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

    // An accepted item reaches the output while out_stall stays low
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall [*3] |=> out_valid)
        else $error("accepted item did not reach output in time");

endmodule

bind block_group_layout_locator_core bgll_checker u_bgll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// ===== sim/block_group_layout_locator_core_test.sv =====
// Self-checking testbench for block_group_layout_locator_core: group start, superblock
// placement and descriptor block location queries across several register settings.
// Depends on bgll_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module block_group_layout_locator_core_test;

    import bgll_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind this index
    localparam int HOLD_CYCLES = 48;
    localparam int PHASE_ITEMS = 150;

    localparam logic [31:0] F_META    = 32'd1 << FLAG_META_BG;
    localparam logic [31:0] F_SPARSE  = 32'd1 << FLAG_SPARSE_SUPER;
    localparam logic [31:0] F_SPARSE2 = 32'd1 << FLAG_SPARSE_SUPER2;
    localparam logic [31:0] F_CLUSTER = 32'd1 << FLAG_CLUSTER_ADJ;

    // Raw register words as written on the config port
    typedef struct {
        logic [31:0] fdb;
        logic [31:0] bpg;
        logic [31:0] dpb;
        logic [31:0] fmb;
        logic [31:0] bka;
        logic [31:0] bkb;
        logic [31:0] flags;
    } layout_cfg_t;

    typedef struct {
        int          prof;
        logic        cmd;
        logic [31:0] index;
        bit          typed;
        logic [32:0] loc;
        logic        sb;
    } probe_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copy used for prediction, at the block's widths
    logic               sh_fdb;
    logic [BPG_W-1:0]   sh_bpg;
    logic [DPB_W-1:0]   sh_dpb;
    logic [GROUP_W-1:0] sh_fmb;
    logic [GROUP_W-1:0] sh_bka;
    logic [GROUP_W-1:0] sh_bkb;
    logic [FLAGS_W-1:0] sh_flags;

    out_item_t pending_locations [$];
    int        mismatches = 0;
    int        send_idle_pct = 8;
    int        recv_stall_pct = 76;
    int        hold_ticket = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    layout_cfg_t profiles [5] = '{
        '{32'd0, 32'd32768, 32'd128, 32'd0, 32'd1, 32'd0, F_SPARSE},
        '{32'd1, 32'd8, 32'd4, 32'd3, 32'd0, 32'd12, F_META | F_SPARSE | F_SPARSE2 | F_CLUSTER},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, F_META},
        '{32'd0, 32'd524288, 32'd2048, 32'd1, 32'd1, 32'd0, F_META | F_SPARSE}
    };

    probe_row_t probes [25] = '{
        '{0, CMD_GROUP, 32'd0,          1, 33'd0,           1'b1},
        '{0, CMD_GROUP, 32'd1,          1, 33'd32768,       1'b1},
        '{0, CMD_GROUP, 32'd2,          1, 33'd65536,       1'b0},
        '{0, CMD_GROUP, 32'd15,         1, 33'd491520,      1'b0},
        '{0, CMD_GROUP, 32'd3,          1, 33'd98304,       1'b1},
        '{0, CMD_GROUP, 32'd25,         1, 33'd819200,      1'b1},
        '{0, CMD_GROUP, 32'd49,         1, 33'd1605632,     1'b1},
        '{0, CMD_GROUP, 32'hFFFFFFFF,   1, 33'h0FFFF8000,   1'b0},
        '{0, CMD_GROUP, 32'd3486784401, 0, 33'd0,           1'b0},
        '{0, CMD_DESC,  32'd0,          1, 33'd1,           1'b1},
        '{0, CMD_DESC,  32'hFFFFFFFF,   1, 33'h100000000,   1'b1},
        '{1, CMD_DESC,  32'd2,          0, 33'd0,           1'b0},
        '{1, CMD_DESC,  32'd3,          0, 33'd0,           1'b0},
        '{1, CMD_DESC,  32'd4,          0, 33'd0,           1'b0},
        '{1, CMD_GROUP, 32'd0,          0, 33'd0,           1'b0},
        '{1, CMD_GROUP, 32'd12,         0, 33'd0,           1'b0},
        '{1, CMD_GROUP, 32'd1,          0, 33'd0,           1'b0},
        '{2, CMD_GROUP, 32'hFFFFFFFF,   0, 33'd0,           1'b0},
        '{2, CMD_DESC,  32'hFFFFFFFE,   0, 33'd0,           1'b0},
        '{2, CMD_DESC,  32'hFFFFFFFF,   0, 33'd0,           1'b0},
        '{3, CMD_GROUP, 32'd7,          0, 33'd0,           1'b0},
        '{3, CMD_DESC,  32'd5,          0, 33'd0,           1'b0},
        '{4, CMD_DESC,  32'd0,          0, 33'd0,           1'b0},
        '{4, CMD_DESC,  32'd1,          0, 33'd0,           1'b0},
        '{4, CMD_GROUP, 32'd8191,       0, 33'd0,           1'b0}
    };

    block_group_layout_locator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // True when n is r, r*r, r*r*r and so on
    function automatic bit exact_power(logic [31:0] n, logic [31:0] r);
        while (n >= r)
        begin
            if (n == r)
                return 1'b1;
            if (n % r != 0)
                return 1'b0;
            n = n / r;
        end
        return 1'b0;
    endfunction

    function automatic bit holds_super_copy(logic [31:0] g);
        if (g == 0)
            return 1'b1;
        if (sh_flags[FLAG_SPARSE_SUPER2])
            return (g == sh_bka) || (g == sh_bkb);
        if (g <= 1 || !sh_flags[FLAG_SPARSE_SUPER])
            return 1'b1;
        if (!g[0])
            return 1'b0;
        return exact_power(g, 3) || exact_power(g, 5) || exact_power(g, 7);
    endfunction

    // First block of group g, wrapped to 32 bits
    function automatic logic [31:0] group_start_block(logic [31:0] g);
        logic [31:0] b;
        b = g * sh_bpg;
        b = b + sh_fdb;
        if (g == 0 && sh_flags[FLAG_CLUSTER_ADJ])
            b = b + 32'd1;
        return b;
    endfunction

    function automatic out_item_t locate_query(in_item_t q);
        out_item_t   r;
        logic [31:0] g;
        if (q.cmd == CMD_GROUP)
        begin
            r.location       = {1'b0, group_start_block(q.index)};
            r.has_superblock = holds_super_copy(q.index);
        end
        else if (!sh_flags[FLAG_META_BG] || q.index < sh_fmb)
        begin
            r.location       = {1'b0, group_start_block(32'd0)} + 33'd1 + {1'b0, q.index};
            r.has_superblock = 1'b1;
        end
        else
        begin
            g                = q.index * sh_dpb;
            r.has_superblock = holds_super_copy(g);
            r.location       = {1'b0, group_start_block(g)} + 33'(r.has_superblock);
        end
        return r;
    endfunction

    function automatic logic [31:0] some_power();
        case ($urandom_range(2))
            0: return POW3_TBL[$urandom_range(POW3_N - 1)];
            1: return POW5_TBL[$urandom_range(POW5_N - 1)];
            default: return POW7_TBL[$urandom_range(POW7_N - 1)];
        endcase
    endfunction

    // Bias indexes toward the boundaries the current registers create
    function automatic logic [31:0] pick_index();
        case ($urandom_range(7))
            0: return $urandom_range(8);
            1: return $urandom;
            2: return some_power();
            3: return sh_fmb + 32'($urandom_range(4)) - 32'd2;
            4: return $urandom_range(1) ? sh_bka : sh_bkb;
            5: return 32'hFFFFFFFF - 32'($urandom_range(3));
            6: return $urandom_range(1000);
            default: return {4'($urandom_range(15)), 28'($urandom_range(3))};
        endcase
    endfunction

    function automatic layout_cfg_t random_layout();
        layout_cfg_t s;
        s.fdb = $urandom_range(3) == 0 ? $urandom : $urandom_range(1);
        case ($urandom_range(3))
            0: s.bpg = 32'd0;
            1: s.bpg = 32'd524288;
            2: s.bpg = $urandom_range(1, 64);
            default: s.bpg = $urandom;
        endcase
        case ($urandom_range(3))
            0: s.dpb = 32'd1;
            1: s.dpb = 32'd2048;
            2: s.dpb = $urandom_range(1, 16);
            default: s.dpb = $urandom;
        endcase
        case ($urandom_range(2))
            0: s.fmb = 32'd0;
            1: s.fmb = $urandom_range(20);
            default: s.fmb = $urandom;
        endcase
        s.bka   = $urandom_range(1) ? some_power() : $urandom_range(40);
        s.bkb   = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
        s.flags = $urandom_range(15) | ($urandom_range(1) ? F_META : 32'd0);
        return s;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_FIRST_DATA_BLOCK:      sh_fdb   = val[0];
            REG_BLOCKS_PER_GROUP:      sh_bpg   = val[BPG_W-1:0];
            REG_DESCRIPTORS_PER_BLOCK: sh_dpb   = val[DPB_W-1:0];
            REG_FIRST_META_BG:         sh_fmb   = val;
            REG_BACKUP_GROUP_A:        sh_bka   = val;
            REG_BACKUP_GROUP_B:        sh_bkb   = val;
            REG_FEATURE_FLAGS:         sh_flags = val[FLAGS_W-1:0];
            default:                   ;
        endcase
    endtask

    // Drain the pipeline, then load a full register set plus a write the block must drop
    task automatic reconfigure(layout_cfg_t s);
        in_valid <= 1'b0;
        while (pending_locations.size() != 0)
            @(posedge clk);
        write_reg(REG_FIRST_DATA_BLOCK, s.fdb);
        write_reg(REG_BLOCKS_PER_GROUP, s.bpg);
        write_reg(REG_DESCRIPTORS_PER_BLOCK, s.dpb);
        write_reg(REG_FIRST_META_BG, s.fmb);
        write_reg(REG_BACKUP_GROUP_A, s.bka);
        write_reg(REG_BACKUP_GROUP_B, s.bkb);
        write_reg(REG_FEATURE_FLAGS, s.flags);
        write_reg(REG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic idle_sender();
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one query and hold it until taken; record its expected answer
    task automatic offer_query(in_item_t q, bit typed, out_item_t given);
        in_valid <= 1'b1;
        in_item  <= q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_locations.push_back(typed ? given : locate_query(q));
    endtask

    // Receiver: random stall, or a long hold when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each taken result with the oldest outstanding answer
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_locations.size() == 0)
            begin
                $error("unexpected result: location %h has_superblock %b",
                       out_item.location, out_item.has_superblock);
                mismatches++;
            end
            else
            begin
                want = pending_locations.pop_front();
                if (out_item.location !== want.location)
                begin
                    $error("location: expected %h, got %h", want.location, out_item.location);
                    mismatches++;
                end
                if (out_item.has_superblock !== want.has_superblock)
                begin
                    $error("has_superblock: expected %b, got %b",
                           want.has_superblock, out_item.has_superblock);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int        cur_prof;
        in_item_t  q;
        out_item_t given;

        sh_fdb   = RST_FIRST_DATA_BLOCK;
        sh_bpg   = RST_BLOCKS_PER_GROUP;
        sh_dpb   = RST_DESCRIPTORS_PER_BLOCK;
        sh_fmb   = RST_FIRST_META_BG;
        sh_bka   = RST_BACKUP_GROUP_A;
        sh_bkb   = RST_BACKUP_GROUP_B;
        sh_flags = RST_FEATURE_FLAGS;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries; profile 0 is the reset state and needs no writes
        cur_prof = 0;
        foreach (probes[i])
        begin
            if (probes[i].prof != cur_prof)
            begin
                cur_prof = probes[i].prof;
                reconfigure(profiles[cur_prof]);
            end
            q.cmd                = probes[i].cmd;
            q.index              = probes[i].index;
            given.location       = probes[i].loc;
            given.has_superblock = probes[i].sb;
            idle_sender();
            offer_query(q, probes[i].typed, given);
        end

        // Random phases: receiver-light, sender-light, then full rate
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct  = (p < 2) ? 8 : (p < 4) ? 76 : 0;
            recv_stall_pct = (p < 2) ? 76 : (p < 4) ? 8 : 0;
            case (p)
                1: reconfigure(profiles[4]);
                3: reconfigure(profiles[3]);
                5: reconfigure(profiles[2]);
                default: reconfigure(random_layout());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((p == 2 || p == 4) && n == 40)
                    hold_ticket++;
                q.cmd   = $urandom_range(1);
                q.index = pick_index();
                idle_sender();
                offer_query(q, 1'b0, given);
            end
        end

        // Drain and watch a little longer for stray results
        in_valid <= 1'b0;
        while (pending_locations.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
